[design/ecu_pkg.sv]
package ecu_pkg;

    localparam int TimeBits = 32;
    localparam int SecMin   = 60;
    localparam int SecHour  = 3600;
    localparam int SecDay   = 86400;
    localparam int SecYear  = 31536000;
    localparam int BaseYear = 1970;

    // reciprocal constants: year / 4 / 25, seconds / 128 / 675,
    // seconds / 16 / 225 and seconds / 4 / 15, exact over their ranges
    localparam int CentRecip = 1311;
    localparam int CentShift = 15;
    localparam int DayRecip  = 397683;
    localparam int DayShift  = 28;
    localparam int HourRecip = 9321;
    localparam int HourShift = 21;
    localparam int MinRecip  = 1093;
    localparam int MinShift  = 14;

    typedef logic [TimeBits-1:0] stamp_t;
    typedef logic [TimeBits+1:0] wide_t;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_MON_UP  = 3'd2,
        CMD_MON_DN  = 3'd3,
        CMD_YEAR_UP = 3'd4,
        CMD_YEAR_DN = 3'd5,
        CMD_READ    = 3'd6,
        CMD_SPARE   = 3'd7
    } cmd_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_SPLIT_START,
        OP_SPLIT_YEAR,
        OP_SPLIT_DAY,
        OP_SPLIT_TOD,
        OP_SPLIT_HOUR,
        OP_SPLIT_MONTH,
        OP_MON_FWD1,
        OP_MON_FWD2,
        OP_MON_BCK1,
        OP_MON_BCK2,
        OP_YEAR_FWD,
        OP_YEAR_BCK,
        OP_CNT_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic year_done;
        logic day_done;
        logic month_done;
        logic cnt_zero;
    } sts_t;

    // gregorian rule; centuries found from the year over four by a
    // reciprocal divide by 25
    function automatic logic is_leap(input logic [11:0] y);
        logic [9:0]  qtr;
        logic [20:0] prod;
        logic [5:0]  cent;
        qtr  = y[11:2];
        prod = 21'(qtr) * 21'(CentRecip);
        cent = 6'(prod >> CentShift);
        return (y[1:0] == 2'd0) && ((qtr != 10'(cent) * 10'd25) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd1:                      r = is_leap(y) ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

[design/ecu_datapath.sv]
module ecu_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ecu_pkg::ctl_t     ctl,
    input  logic signed [32:0] value,
    input  logic [7:0]        count,
    output ecu_pkg::sts_t     sts,
    output ecu_pkg::stamp_t   stamp,
    output logic [11:0]       year_out,
    output logic [3:0]        month_out,
    output logic [4:0]        day_out,
    output logic [4:0]        hour_out,
    output logic [5:0]        minute_out
);

    localparam int WB = ecu_pkg::TimeBits + 2;
    localparam ecu_pkg::wide_t Top = ecu_pkg::wide_t'((64'd1 << ecu_pkg::TimeBits) - 64'd1);

    ecu_pkg::stamp_t secs_reg;
    ecu_pkg::stamp_t rem_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [8:0]  day_reg;
    logic [7:0]  cnt_reg;
    logic [16:0] sod_reg;
    logic [4:0]  hour_reg;
    logic [11:0] soh_reg;

    logic [4:0]  cur_len, next_len, prev_len, fwd_k, bck_k;
    logic [25:0] ylen;
    logic        lp_now, lp_adj;
    logic [11:0] year_adj;
    logic signed [WB:0] delta;
    logic signed [WB:0] sum;
    ecu_pkg::stamp_t    clamped;
    logic [3:0] m_next, m_prev;
    logic [36:0] day_prod;
    logic [8:0]  day_q;
    logic [26:0] hour_prod;
    logic [4:0]  hour_q;
    logic [20:0] min_prod;

    // calendar helpers
    always_comb
    begin
        m_next   = (month_reg == 4'd11) ? 4'd0 : month_reg + 4'd1;
        m_prev   = (month_reg == 4'd0) ? 4'd11 : month_reg - 4'd1;
        cur_len  = ecu_pkg::month_len(year_reg, month_reg);
        next_len = ecu_pkg::month_len(year_reg, m_next);
        prev_len = ecu_pkg::month_len(year_reg, m_prev);
        fwd_k    = (day_reg[4:0] - 5'd1 < next_len - 5'd1) ? day_reg[4:0] - 5'd1
                                                           : next_len - 5'd1;
        bck_k    = (day_reg[4:0] < prev_len) ? day_reg[4:0] : prev_len;
        ylen     = ecu_pkg::is_leap(year_reg) ? 26'(ecu_pkg::SecYear + ecu_pkg::SecDay)
                                              : 26'(ecu_pkg::SecYear);
        lp_now   = ecu_pkg::is_leap(year_reg);
        year_adj = (ctl.op == ecu_pkg::OP_YEAR_FWD) ? year_reg + 12'd1 : year_reg - 12'd1;
        lp_adj   = ecu_pkg::is_leap(year_adj);
    end

    // reciprocal splits into day of year, hour and minute
    always_comb
    begin
        day_prod  = 37'(rem_reg[24:7]) * 37'(ecu_pkg::DayRecip);
        day_q     = 9'(day_prod >> ecu_pkg::DayShift);
        hour_prod = 27'(sod_reg[16:4]) * 27'(ecu_pkg::HourRecip);
        hour_q    = 5'(hour_prod >> ecu_pkg::HourShift);
        min_prod  = 21'(soh_reg[11:2]) * 21'(ecu_pkg::MinRecip);
    end

    // signed move amount in seconds
    always_comb
    begin
        delta = '0;
        unique case (ctl.op)
            ecu_pkg::OP_ADD:      delta = (WB+1)'(value);
            ecu_pkg::OP_MON_FWD1: delta = (WB+1)'(17'(ecu_pkg::SecDay) *
                                     (6'(cur_len) - 6'(day_reg[4:0]) + 6'd1));
            ecu_pkg::OP_MON_FWD2: delta = (WB+1)'(17'(ecu_pkg::SecDay) * fwd_k);
            ecu_pkg::OP_MON_BCK1: delta = -(WB+1)'(17'(ecu_pkg::SecDay) * day_reg[4:0]);
            ecu_pkg::OP_MON_BCK2: delta = -(WB+1)'(17'(ecu_pkg::SecDay) *
                                     (prev_len - bck_k));
            ecu_pkg::OP_YEAR_FWD: delta = (WB+1)'(ecu_pkg::SecYear) +
                ((((lp_now && month_reg < 4'd2) ? 1 : 0) +
                  ((lp_adj && month_reg >= 4'd2) ? 1 : 0)) * (WB+1)'(ecu_pkg::SecDay));
            ecu_pkg::OP_YEAR_BCK: delta = -((WB+1)'(ecu_pkg::SecYear) +
                ((((lp_now && month_reg >= 4'd2) ? 1 : 0) +
                  ((lp_adj && month_reg < 4'd2) ? 1 : 0)) * (WB+1)'(ecu_pkg::SecDay)));
            default:              delta = '0;
        endcase
        sum = (ctl.op == ecu_pkg::OP_LOAD) ? (WB+1)'(value)
                                           : $signed({2'b0, secs_reg}) + delta;
        if (sum < 0)
            clamped = '0;
        else if (sum > $signed({1'b0, Top}))
            clamped = Top[ecu_pkg::TimeBits-1:0];
        else
            clamped = sum[ecu_pkg::TimeBits-1:0];
    end

    // state and split registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secs_reg  <= '0;
            rem_reg   <= '0;
            year_reg  <= 12'(ecu_pkg::BaseYear);
            month_reg <= '0;
            day_reg   <= 9'd1;
            cnt_reg   <= '0;
            sod_reg   <= '0;
            hour_reg  <= '0;
            soh_reg   <= '0;
        end
        else
        begin
            unique case (ctl.op)
                ecu_pkg::OP_LOAD, ecu_pkg::OP_ADD, ecu_pkg::OP_MON_FWD1,
                ecu_pkg::OP_MON_FWD2, ecu_pkg::OP_MON_BCK1, ecu_pkg::OP_MON_BCK2:
                    secs_reg <= clamped;
                ecu_pkg::OP_YEAR_FWD, ecu_pkg::OP_YEAR_BCK:
                begin
                    secs_reg <= clamped;
                    year_reg <= year_adj;
                    cnt_reg  <= cnt_reg - 8'd1;
                end
                ecu_pkg::OP_CNT_LOAD:
                    cnt_reg <= count;
                ecu_pkg::OP_SPLIT_START:
                begin
                    rem_reg   <= secs_reg;
                    year_reg  <= 12'(ecu_pkg::BaseYear);
                    month_reg <= '0;
                end
                ecu_pkg::OP_SPLIT_YEAR:
                    if (!sts.year_done)
                    begin
                        rem_reg  <= rem_reg - ecu_pkg::stamp_t'(ylen);
                        year_reg <= year_reg + 12'd1;
                    end
                ecu_pkg::OP_SPLIT_DAY:
                    // remainder is below one leap year: 9 quotient bits
                    day_reg <= day_q + 9'd1;
                ecu_pkg::OP_SPLIT_TOD:
                    sod_reg <= 17'(rem_reg[24:0] -
                                   25'(day_reg - 9'd1) * 25'(ecu_pkg::SecDay));
                ecu_pkg::OP_SPLIT_HOUR:
                begin
                    hour_reg <= hour_q;
                    soh_reg  <= 12'(sod_reg - 17'(hour_q) * 17'(ecu_pkg::SecHour));
                end
                ecu_pkg::OP_SPLIT_MONTH:
                    if (!sts.month_done)
                    begin
                        day_reg   <= day_reg - 9'(cur_len);
                        month_reg <= month_reg + 4'd1;
                    end
                default: ;
            endcase
            if (ctl.op == ecu_pkg::OP_MON_BCK2 || ctl.op == ecu_pkg::OP_MON_FWD2)
                cnt_reg <= cnt_reg - 8'd1;
        end
    end

    // status
    always_comb
    begin
        sts.year_done  = (rem_reg < ecu_pkg::stamp_t'(ylen)) || (year_reg == 12'hFFF);
        sts.day_done   = 1'b1;
        sts.month_done = (month_reg == 4'd11) || (day_reg <= 9'(cur_len));
        sts.cnt_zero   = (cnt_reg == 8'd0);
    end

    // result fields
    assign stamp      = secs_reg;
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg[4:0];
    assign hour_out   = hour_reg;
    assign minute_out = 6'(min_prod >> ecu_pkg::MinShift);

endmodule

[design/ecu_ctrl.sv]
module ecu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    cmd,
    output logic          out_valid,
    input  logic          out_stall,
    output ecu_pkg::ctl_t ctl,
    input  ecu_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_SPLIT0, S_YEARS, S_DAYS, S_MONTHS,
        S_STEP, S_STEP2, S_FINAL0, S_FYEARS, S_FDAYS, S_FTOD, S_FHOUR,
        S_FMONTHS, S_OUT
    } state_t;

    state_t      state_reg;
    ecu_pkg::cmd_t cmd_reg;
    logic        out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // command decode to datapath operation
    always_comb
    begin
        ctl.op = ecu_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (cmd == ecu_pkg::CMD_SET)      ctl.op = ecu_pkg::OP_LOAD;
                    else if (cmd == ecu_pkg::CMD_ADD) ctl.op = ecu_pkg::OP_ADD;
                    else                              ctl.op = ecu_pkg::OP_CNT_LOAD;
                end
            S_SPLIT0, S_FINAL0: ctl.op = ecu_pkg::OP_SPLIT_START;
            S_YEARS, S_FYEARS:  ctl.op = ecu_pkg::OP_SPLIT_YEAR;
            S_DAYS, S_FDAYS:    ctl.op = ecu_pkg::OP_SPLIT_DAY;
            S_FTOD:             ctl.op = ecu_pkg::OP_SPLIT_TOD;
            S_FHOUR:            ctl.op = ecu_pkg::OP_SPLIT_HOUR;
            S_MONTHS, S_FMONTHS: ctl.op = ecu_pkg::OP_SPLIT_MONTH;
            S_STEP:
                if (!sts.cnt_zero)
                begin
                    unique case (cmd_reg)
                        ecu_pkg::CMD_MON_UP:  ctl.op = ecu_pkg::OP_MON_FWD1;
                        ecu_pkg::CMD_MON_DN:  ctl.op = ecu_pkg::OP_MON_BCK1;
                        ecu_pkg::CMD_YEAR_UP: ctl.op = ecu_pkg::OP_YEAR_FWD;
                        ecu_pkg::CMD_YEAR_DN: ctl.op = ecu_pkg::OP_YEAR_BCK;
                        default:              ctl.op = ecu_pkg::OP_NONE;
                    endcase
                end
            S_STEP2:
                ctl.op = (cmd_reg == ecu_pkg::CMD_MON_UP) ? ecu_pkg::OP_MON_FWD2
                                                           : ecu_pkg::OP_MON_BCK2;
            default: ctl.op = ecu_pkg::OP_NONE;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= ecu_pkg::CMD_READ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cmd_reg <= ecu_pkg::cmd_t'(cmd);
                        state_reg <= S_SPLIT0;
                    end
                S_SPLIT0: state_reg <= S_YEARS;
                S_YEARS:  if (sts.year_done) state_reg <= S_DAYS;
                S_DAYS:   state_reg <= S_MONTHS;
                S_MONTHS: if (sts.month_done) state_reg <= S_STEP;
                S_STEP:
                    if (sts.cnt_zero)
                        state_reg <= S_FINAL0;
                    else if (cmd_reg == ecu_pkg::CMD_MON_UP || cmd_reg == ecu_pkg::CMD_MON_DN)
                        state_reg <= S_STEP2;
                    else if (cmd_reg != ecu_pkg::CMD_YEAR_UP && cmd_reg != ecu_pkg::CMD_YEAR_DN)
                        state_reg <= S_FINAL0;
                S_STEP2:   state_reg <= S_SPLIT0;
                S_FINAL0:  state_reg <= S_FYEARS;
                S_FYEARS:  if (sts.year_done) state_reg <= S_FDAYS;
                S_FDAYS:   state_reg <= S_FTOD;
                S_FTOD:    state_reg <= S_FHOUR;
                S_FHOUR:   state_reg <= S_FMONTHS;
                S_FMONTHS:
                    if (sts.month_done)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[design/epoch_calendar_unit_top.sv]
// epoch calendar unit: keeps a seconds count since 1970 and breaks it down
// into year, month (0 is january), day, hour and minute.
// input channel: in_valid / in_stall with cmd, value and count; one item is
// taken only while the unit is idle, so in_stall is high while it works.
// output channel: out_valid / out_stall carrying one result item per input
// item: stamp and its calendar fields.
// sequence: a breakdown walks the years from 1970 one at a time and then
// the months; the count is broken down before the command and again after
// it. a month command breaks the count down again after every month step.
// flow: one item at a time; the next item is taken after the result leaves.
// reset clears the count to 0 (1970-01-01 00:00) and idles both channels.
// a stalled result holds on the output until taken; no new item is taken
// meanwhile.
module epoch_calendar_unit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [32:0] value,
    input  logic [7:0]         count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        stamp,
    output logic [11:0]        year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic [4:0]         hour_out,
    output logic [5:0]         minute_out
);

    ecu_pkg::ctl_t ctl;
    ecu_pkg::sts_t sts;

    ecu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    ecu_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .value      (value),
        .count      (count),
        .sts        (sts),
        .stamp      (stamp),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out)
    );

    // no new item while a result is pending
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item taken while result pending");

    // result fields sane
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_out <= 4'd11 && day_out != 5'd0))
        else $error("bad calendar result");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stamp))
        else $error("result changed under stall");

endmodule
